>>> rtl/core/spa_pkg.sv
// ============================================================================
// spa_pkg: shared types and constants for the sparse polynomial adder
// Term and word layouts, command kinds, status codes and back-end states.
// ============================================================================
package spa_pkg;

    // Number of terms each list can hold (1 to 32)
    localparam int MAX_TERMS = 32;
    localparam int ADDR_W    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TERMS);

    // Command queue between front and back, power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QCNT_W-1:0] QUEUE_FULL = QCNT_W'(QUEUE_DEPTH);

    localparam int COEF_W = 32;
    localparam int DEG_W  = 16;
    localparam int TERM_W = COEF_W + DEG_W;

    localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    typedef enum logic [1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_MERGE  = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_TERM  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        K_LOAD_A = 2'd0,
        K_LOAD_B = 2'd1,
        K_MERGE  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_FETCH = 2'd1,
        S_EMIT  = 2'd2
    } t_state;

    typedef struct packed {
        t_opcode                   opcode;
        logic signed [COEF_W-1:0]  term_coef;
        logic [DEG_W-1:0]          term_degree;
    } t_in_word;

    typedef struct packed {
        logic signed [COEF_W-1:0]  out_coef;
        logic [DEG_W-1:0]          out_degree;
        t_status                   status;
        logic                      last;
    } t_out_word;

    typedef struct packed {
        logic signed [COEF_W-1:0]  coef;
        logic [DEG_W-1:0]          degree;
    } t_term;

    // Classified command handed from front to back
    typedef struct packed {
        t_kind  kind;
        t_term  term;
    } t_cmd;

    typedef struct packed {
        logic  valid;
        t_cmd  cmd;
    } t_cmd_head;

endpackage

>>> rtl/core/spa_ram.sv
// ============================================================================
// spa_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
module spa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/spa_front.sv
// ============================================================================
// spa_front: input side
// Accepts input words, sorts them into command kinds, drops unused opcodes
// and holds commands in a short queue for the back end.
// ============================================================================
module spa_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  spa_pkg::t_in_word  i_in_word,
    output spa_pkg::t_cmd_head o_head,
    input  logic               i_pop
);

    spa_pkg::t_cmd                   r_q [spa_pkg::QUEUE_DEPTH];
    logic [spa_pkg::QPTR_W-1:0]      r_wp, n_wp;
    logic [spa_pkg::QPTR_W-1:0]      r_rp, n_rp;
    logic [spa_pkg::QCNT_W-1:0]      r_cnt, n_cnt;
    spa_pkg::t_cmd                   cmd_in;
    logic                            accept;
    logic                            push;
    logic                            pop;

    // classify
    always_comb begin
        cmd_in.term.coef   = i_in_word.term_coef;
        cmd_in.term.degree = i_in_word.term_degree;
        push               = 1'b0;
        cmd_in.kind        = spa_pkg::K_MERGE;
        unique case (i_in_word.opcode)
            spa_pkg::OP_LOAD_A: begin
                cmd_in.kind = spa_pkg::K_LOAD_A;
                push        = accept;
            end
            spa_pkg::OP_LOAD_B: begin
                cmd_in.kind = spa_pkg::K_LOAD_B;
                push        = accept;
            end
            spa_pkg::OP_MERGE: begin
                cmd_in.kind = spa_pkg::K_MERGE;
                push        = accept;
            end
            default: begin
                push = 1'b0;    // unused opcode: taken and dropped
            end
        endcase
    end

    assign o_in_stall = (r_cnt == spa_pkg::QUEUE_FULL);
    assign accept     = i_in_valid && !o_in_stall;
    assign pop        = i_pop && (r_cnt != '0);

    always_comb begin
        n_wp  = push ? r_wp + 1'b1 : r_wp;
        n_rp  = pop  ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + spa_pkg::QCNT_W'(push) - spa_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_q[r_rp];

endmodule

>>> rtl/core/spa_back.sv
// ============================================================================
// spa_back: command execution
// Writes loaded terms into the list RAMs, reports full lists and empty
// merges, walks both lists for a merge and drives the output register.
// ============================================================================
module spa_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spa_pkg::t_cmd_head i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output spa_pkg::t_out_word o_out_word
);

    spa_pkg::t_state              r_state, n_state;
    logic [spa_pkg::CNT_W-1:0]    r_cnt_a, n_cnt_a;
    logic [spa_pkg::CNT_W-1:0]    r_cnt_b, n_cnt_b;
    logic [spa_pkg::CNT_W-1:0]    r_ia, n_ia;
    logic [spa_pkg::CNT_W-1:0]    r_ib, n_ib;
    logic                         r_out_valid, n_out_valid;
    spa_pkg::t_out_word           r_out_word;

    logic [spa_pkg::TERM_W-1:0]   rd_a, rd_b;
    spa_pkg::t_term               term_a, term_b;
    logic                         we_a, we_b;
    logic                         out_free;
    logic                         a_full, b_full, both_empty;
    logic                         a_has, b_has, take_a, take_b;
    logic                         merge_last;
    logic                         emit, start, step, finish;
    logic [spa_pkg::COEF_W:0]     sum;
    logic signed [spa_pkg::COEF_W-1:0] sat_coef;
    spa_pkg::t_out_word           merge_word, emit_word;

    spa_ram #(.WIDTH(spa_pkg::TERM_W), .DEPTH(spa_pkg::MAX_TERMS)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_cnt_a[spa_pkg::ADDR_W-1:0]),
        .i_wdata (i_head.cmd.term),
        .i_raddr (r_ia[spa_pkg::ADDR_W-1:0]),
        .o_rdata (rd_a)
    );

    spa_ram #(.WIDTH(spa_pkg::TERM_W), .DEPTH(spa_pkg::MAX_TERMS)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_cnt_b[spa_pkg::ADDR_W-1:0]),
        .i_wdata (i_head.cmd.term),
        .i_raddr (r_ib[spa_pkg::ADDR_W-1:0]),
        .o_rdata (rd_b)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign a_full     = (r_cnt_a == spa_pkg::MAX_CNT);
    assign b_full     = (r_cnt_b == spa_pkg::MAX_CNT);
    assign both_empty = (r_cnt_a == '0) && (r_cnt_b == '0);

    // merge step: pick higher degree, add on equal degrees
    always_comb begin
        term_a = spa_pkg::t_term'(rd_a);
        term_b = spa_pkg::t_term'(rd_b);
        a_has  = (r_ia < r_cnt_a);
        b_has  = (r_ib < r_cnt_b);
        take_a = a_has && (!b_has || (term_a.degree >= term_b.degree));
        take_b = b_has && (!a_has || (term_b.degree >= term_a.degree));
        sum    = {term_a.coef[spa_pkg::COEF_W-1], term_a.coef}
               + {term_b.coef[spa_pkg::COEF_W-1], term_b.coef};
        if (sum[spa_pkg::COEF_W] != sum[spa_pkg::COEF_W-1]) begin
            sat_coef = sum[spa_pkg::COEF_W] ? spa_pkg::COEF_MIN : spa_pkg::COEF_MAX;
        end else begin
            sat_coef = sum[spa_pkg::COEF_W-1:0];
        end
        merge_last = ((r_ia + spa_pkg::CNT_W'(take_a)) == r_cnt_a)
                  && ((r_ib + spa_pkg::CNT_W'(take_b)) == r_cnt_b);
        merge_word.out_coef   = (take_a && take_b) ? sat_coef
                              : (take_a ? term_a.coef : term_b.coef);
        merge_word.out_degree = take_a ? term_a.degree : term_b.degree;
        merge_word.status     = spa_pkg::ST_TERM;
        merge_word.last       = merge_last;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            spa_pkg::S_IDLE: begin
                if (i_head.valid && (i_head.cmd.kind == spa_pkg::K_MERGE) && !both_empty) begin
                    n_state = spa_pkg::S_FETCH;
                end
            end
            spa_pkg::S_FETCH: begin
                n_state = spa_pkg::S_EMIT;
            end
            spa_pkg::S_EMIT: begin
                if (out_free) begin
                    n_state = merge_last ? spa_pkg::S_IDLE : spa_pkg::S_FETCH;
                end
            end
            default: begin
                n_state = spa_pkg::S_IDLE;
            end
        endcase
    end

    // controls
    always_comb begin
        o_pop     = 1'b0;
        we_a      = 1'b0;
        we_b      = 1'b0;
        emit      = 1'b0;
        start     = 1'b0;
        step      = 1'b0;
        finish    = 1'b0;
        emit_word = merge_word;
        unique case (r_state)
            spa_pkg::S_IDLE: begin
                if (i_head.valid) begin
                    unique case (i_head.cmd.kind)
                        spa_pkg::K_LOAD_A, spa_pkg::K_LOAD_B: begin
                            if (i_head.cmd.kind == spa_pkg::K_LOAD_A ? !a_full : !b_full) begin
                                we_a  = (i_head.cmd.kind == spa_pkg::K_LOAD_A);
                                we_b  = (i_head.cmd.kind == spa_pkg::K_LOAD_B);
                                o_pop = 1'b1;
                            end else if (out_free) begin
                                emit      = 1'b1;
                                o_pop     = 1'b1;
                                emit_word = '{out_coef: '0, out_degree: '0,
                                              status: spa_pkg::ST_FULL, last: 1'b1};
                            end
                        end
                        spa_pkg::K_MERGE: begin
                            if (!both_empty) begin
                                start = 1'b1;
                                o_pop = 1'b1;
                            end else if (out_free) begin
                                emit      = 1'b1;
                                o_pop     = 1'b1;
                                emit_word = '{out_coef: '0, out_degree: '0,
                                              status: spa_pkg::ST_EMPTY, last: 1'b1};
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            spa_pkg::S_FETCH: begin
                // RAM read in flight
            end
            spa_pkg::S_EMIT: begin
                if (out_free) begin
                    emit   = 1'b1;
                    step   = 1'b1;
                    finish = merge_last;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_ia        = r_ia;
        n_ib        = r_ib;
        n_out_valid = r_out_valid && i_out_stall;
        if (we_a) begin
            n_cnt_a = r_cnt_a + 1'b1;
        end
        if (we_b) begin
            n_cnt_b = r_cnt_b + 1'b1;
        end
        if (start) begin
            n_ia = '0;
            n_ib = '0;
        end else if (step) begin
            n_ia = r_ia + spa_pkg::CNT_W'(take_a);
            n_ib = r_ib + spa_pkg::CNT_W'(take_b);
        end
        if (finish) begin
            n_cnt_a = '0;
            n_cnt_b = '0;
        end
        if (emit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spa_pkg::S_IDLE;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_ia        <= '0;
            r_ib        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt_a     <= n_cnt_a;
            r_cnt_b     <= n_cnt_b;
            r_ia        <= n_ia;
            r_ib        <= n_ib;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_word <= emit_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // list fill never passes capacity
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_a <= spa_pkg::MAX_CNT) && (r_cnt_b <= spa_pkg::MAX_CNT))
        else $error("list count beyond capacity");

    // while merging at least one list still has terms left
    a_walk_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != spa_pkg::S_IDLE) |-> (a_has || b_has))
        else $error("merge walk past both lists");

    // the final merged term empties both lists
    a_clear_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> (r_cnt_a == '0) && (r_cnt_b == '0) && (r_state == spa_pkg::S_IDLE))
        else $error("lists not cleared after merge");

    // no command is taken from the queue mid-merge
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == spa_pkg::S_IDLE) && i_head.valid)
        else $error("queue pop outside idle");

    // a new result only goes where the output slot is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> out_free)
        else $error("output word overwritten");

endmodule

>>> rtl/core/sparse_polynomial_add_top.sv
// ============================================================================
// sparse_polynomial_add_top: sparse polynomial adder, sorted-list merge
// Loads two term lists and merges them into one sum polynomial on request.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_word): a word is taken at a
//   clock edge with valid high and stall low. Opcode LOAD_A / LOAD_B appends
//   a term to list A / B (lists sorted by falling degree), MERGE emits the
//   merged sum, opcode 3 is taken and dropped.
//   Output channel (o_out_valid / i_out_stall / o_out_word): one word per
//   merged term, last set on the final one. A merge of two empty lists gives
//   one EMPTY word; a load into a full list gives one FULL word.
//   Rate: input words go into a two-entry command queue, so loads stream at
//   one per cycle unless a merge or a stalled FULL report holds the back
//   end. The back end writes a term in the same cycle that it pops it. A
//   merge leaves the queue, then for each result term the back end reads
//   both list RAMs (registered read), then compares and loads the output
//   register.
//   When the receiver stalls, the output register holds its word and the back
//   end waits; the queue keeps accepting until its two entries are full.
//   Reset (synchronous, active low) empties the queue and both lists; RAM
//   contents are not cleared, reads stop at each list's fill count.
module sparse_polynomial_add_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  spa_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output spa_pkg::t_out_word o_out_word
);

    spa_pkg::t_cmd_head head;   // queue head seen by the back end
    logic               pop;

    // front: classify and queue
    spa_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_head     (head),
        .i_pop      (pop)
    );

    // back: list stores, merge walk, output register
    spa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule
